[src/ecint_pkg.sv]
// shared widths, curve codes and curve decode for the easing curve interpolator
package ecint_pkg;

   localparam int KIND_BITS     = 4;
   localparam int PROGRESS_BITS = 17;
   localparam int FRAC_BITS     = 16;

   localparam logic [PROGRESS_BITS-1:0] ONE_Q16  = 17'h10000;
   localparam logic [PROGRESS_BITS-1:0] HALF_Q16 = 17'h08000;

   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

   localparam logic [KIND_BITS-1:0] KIND_SINE_IN    = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_SINE_OUT   = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_SINE_INOUT = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_QUAD_IN    = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_QUAD_OUT   = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_QUAD_INOUT = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_CUBE_IN    = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_CUBE_OUT   = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_CUBE_INOUT = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_QUART_IN    = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_QUART_OUT   = 4'd10;
   localparam logic [KIND_BITS-1:0] KIND_QUART_INOUT = 4'd11;

   typedef enum logic [1:0] {
      FAMILY_NONE,
      FAMILY_SINE,
      FAMILY_POWER
   } family_type;

   typedef enum logic [1:0] {
      MODE_IN,
      MODE_OUT,
      MODE_INOUT
   } mode_type;

   typedef enum logic [1:0] {
      ORDER_QUAD,
      ORDER_CUBIC,
      ORDER_QUART
   } order_type;

   typedef struct packed {
      family_type family;
      mode_type   mode;
      order_type  order;
   } curve_type;

   function automatic curve_type decode_kind(input logic [KIND_BITS-1:0] kind);
      curve_type c;
      c = '{family: FAMILY_NONE, mode: MODE_IN, order: ORDER_QUAD};
      unique case (kind)
         KIND_SINE_IN:     c = '{family: FAMILY_SINE,  mode: MODE_IN,    order: ORDER_QUAD};
         KIND_SINE_OUT:    c = '{family: FAMILY_SINE,  mode: MODE_OUT,   order: ORDER_QUAD};
         KIND_SINE_INOUT:  c = '{family: FAMILY_SINE,  mode: MODE_INOUT, order: ORDER_QUAD};
         KIND_QUAD_IN:     c = '{family: FAMILY_POWER, mode: MODE_IN,    order: ORDER_QUAD};
         KIND_QUAD_OUT:    c = '{family: FAMILY_POWER, mode: MODE_OUT,   order: ORDER_QUAD};
         KIND_QUAD_INOUT:  c = '{family: FAMILY_POWER, mode: MODE_INOUT, order: ORDER_QUAD};
         KIND_CUBE_IN:     c = '{family: FAMILY_POWER, mode: MODE_IN,    order: ORDER_CUBIC};
         KIND_CUBE_OUT:    c = '{family: FAMILY_POWER, mode: MODE_OUT,   order: ORDER_CUBIC};
         KIND_CUBE_INOUT:  c = '{family: FAMILY_POWER, mode: MODE_INOUT, order: ORDER_CUBIC};
         KIND_QUART_IN:    c = '{family: FAMILY_POWER, mode: MODE_IN,    order: ORDER_QUART};
         KIND_QUART_OUT:   c = '{family: FAMILY_POWER, mode: MODE_OUT,   order: ORDER_QUART};
         KIND_QUART_INOUT: c = '{family: FAMILY_POWER, mode: MODE_INOUT, order: ORDER_QUART};
         default:          c = '{family: FAMILY_NONE,  mode: MODE_IN,    order: ORDER_QUAD};
      endcase
      return c;
   endfunction

endpackage

[src/ecint_req_if.sv]
// request channel carrying one easing item: curve kind, end points and progress
interface ecint_req_if #(
   parameter int VALUE_BITS = 32
) ();
   logic                                    valid;
   logic                                    ready;
   logic [ecint_pkg::KIND_BITS-1:0]         kind;
   logic signed [VALUE_BITS-1:0]            start_value;
   logic signed [VALUE_BITS-1:0]            end_value;
   logic [ecint_pkg::PROGRESS_BITS-1:0]     progress;

   modport source (output valid, kind, start_value, end_value, progress, input ready);
   modport sink   (input valid, kind, start_value, end_value, progress, output ready);
endinterface

[src/ecint_rsp_if.sv]
// response channel carrying one eased value
interface ecint_rsp_if #(
   parameter int VALUE_BITS = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] eased_value;

   modport source (output valid, eased_value, input ready);
   modport sink   (input valid, eased_value, output ready);
endinterface

[src/easing_curve_interpolator_unit.sv]
// easing curve interpolator: seven-stage pipeline from curve kind and progress to eased value
//
// Takes one item per cycle while the output is not stalled and returns one eased value
// per item, in order. Stages: input capture and end-point difference; sine angle scaling
// and square of the power base; registered two-port read of the quarter-wave sine table
// and the third or fourth power; table interpolation and power rounding; easing factor
// select; difference times factor; rounding and add to the start value. Each stage holds
// its own valid bit and loads whenever it is empty or its successor moves, so req ready
// drops only when all seven stages hold items. The sine table of SINE_TABLE_ENTRIES+1
// entries is a constant worked out at elaboration.
module easing_curve_interpolator_unit #(
   parameter int SINE_TABLE_ENTRIES = 256,
   parameter int VALUE_BITS         = 32
) (
   input logic          clock,
   input logic          reset,
   ecint_req_if.sink    req_bus,
   ecint_rsp_if.source  rsp_bus
);

   localparam int STAGES     = 7;
   localparam int LAST       = STAGES - 1;
   localparam int IDX_BITS   = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int ANGLE_BITS = ecint_pkg::PROGRESS_BITS + IDX_BITS;
   localparam int DIF_BITS   = VALUE_BITS + 1;
   localparam int PROD_BITS  = DIF_BITS + ecint_pkg::PROGRESS_BITS + 1;
   localparam int POW_BITS   = 67;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SINE_TABLE_ENTRIES);

   // sine table build, elaboration only

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = {64'b0, a} * {64'b0, b};
      return wide[125:62];
   endfunction

   function automatic logic [63:0] series_div(input logic [63:0] v, input int k);
      logic [63:0] r;
      unique case (k)
         1:       r = v / 6;
         2:       r = v / 20;
         3:       r = v / 42;
         4:       r = v / 72;
         5:       r = v / 110;
         6:       r = v / 156;
         7:       r = v / 210;
         8:       r = v / 272;
         9:       r = v / 342;
         10:      r = v / 420;
         11:      r = v / 506;
         12:      r = v / 600;
         13:      r = v / 702;
         14:      r = v / 812;
         15:      r = v / 930;
         16:      r = v / 1056;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] sine_entry(input int unsigned idx);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x = (ecint_pkg::HALF_PI_Q62 / 64'(SINE_TABLE_ENTRIES)) * 64'(idx)
        + ((ecint_pkg::HALF_PI_Q62 % 64'(SINE_TABLE_ENTRIES)) * 64'(idx))
          / 64'(SINE_TABLE_ENTRIES);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k < 40; k++) begin
         if (term != '0) begin
            term = series_div(mul_q62(term, x2), k);
            if (k % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      sum = (sum + 64'h0000_2000_0000_0000) >> 46;
      return sum[16:0];
   endfunction

   logic [16:0] sine_rom [SINE_TABLE_ENTRIES+1];

   for (genvar g = 0; g <= SINE_TABLE_ENTRIES; g++) begin : g_rom
      assign sine_rom[g] = sine_entry(g);
   end

   // pipeline control

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[LAST] = !vld_ff[LAST] || rsp_bus.ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign vld_in = {vld_ff[LAST-1:0], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_bus.ready = adv[0];

   // stage 1: capture, saturate progress, end-point difference

   ecint_pkg::curve_type                    s1_curve_ff;
   logic [ecint_pkg::PROGRESS_BITS-1:0]     s1_t_ff;
   logic [ecint_pkg::PROGRESS_BITS-1:0]     s1_t_in;
   logic signed [VALUE_BITS-1:0]            s1_start_ff;
   logic signed [DIF_BITS-1:0]              s1_dif_ff;
   logic signed [DIF_BITS-1:0]              s1_dif_in;

   assign s1_t_in   = (req_bus.progress > ecint_pkg::ONE_Q16) ? ecint_pkg::ONE_Q16
                                                              : req_bus.progress;
   assign s1_dif_in = DIF_BITS'(req_bus.end_value) - DIF_BITS'(req_bus.start_value);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_curve_ff <= ecint_pkg::decode_kind(req_bus.kind);
         s1_t_ff     <= s1_t_in;
         s1_start_ff <= req_bus.start_value;
         s1_dif_ff   <= s1_dif_in;
      end
   end

   // stage 2: sine table position and power base squared

   ecint_pkg::curve_type                    s2_curve_ff;
   logic                                    s2_upper_ff;
   logic                                    s2_upper_in;
   logic signed [VALUE_BITS-1:0]            s2_start_ff;
   logic signed [DIF_BITS-1:0]              s2_dif_ff;
   logic [IDX_BITS-1:0]                     s2_idx_ff;
   logic [ecint_pkg::FRAC_BITS-1:0]         s2_frac_ff;
   logic [15:0]                             s2_x_ff;
   logic                                    s2_xfull_ff;
   logic [31:0]                             s2_x2_ff;
   logic [31:0]                             s2_x2_in;
   logic [17:0]                             t_double;
   logic [ecint_pkg::PROGRESS_BITS-1:0]     angle;
   logic [ANGLE_BITS-1:0]                   angle_scaled;
   logic [ecint_pkg::PROGRESS_BITS-1:0]     base;

   assign s2_upper_in = s1_t_ff >= ecint_pkg::HALF_Q16;
   assign t_double    = {s1_t_ff, 1'b0};

   always_comb begin
      unique case (s1_curve_ff.mode)
         ecint_pkg::MODE_IN: begin
            angle = ecint_pkg::ONE_Q16 - s1_t_ff;
            base  = s1_t_ff;
         end
         ecint_pkg::MODE_OUT: begin
            angle = s1_t_ff;
            base  = ecint_pkg::ONE_Q16 - s1_t_ff;
         end
         ecint_pkg::MODE_INOUT: begin
            if (s2_upper_in) begin
               angle = 17'(t_double - 18'(ecint_pkg::ONE_Q16));
               base  = ecint_pkg::ONE_Q16 - s1_t_ff;
            end else begin
               angle = 17'(18'(ecint_pkg::ONE_Q16) - t_double);
               base  = s1_t_ff;
            end
         end
         default: begin
            angle = s1_t_ff;
            base  = s1_t_ff;
         end
      endcase
   end

   assign angle_scaled = ANGLE_BITS'(angle) * ANGLE_BITS'(SINE_TABLE_ENTRIES);
   assign s2_x2_in     = 32'(base[15:0]) * 32'(base[15:0]);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_curve_ff <= s1_curve_ff;
         s2_upper_ff <= s2_upper_in;
         s2_start_ff <= s1_start_ff;
         s2_dif_ff   <= s1_dif_ff;
         s2_idx_ff   <= angle_scaled[ecint_pkg::FRAC_BITS +: IDX_BITS];
         s2_frac_ff  <= angle_scaled[ecint_pkg::FRAC_BITS-1:0];
         s2_x_ff     <= base[15:0];
         s2_xfull_ff <= base == ecint_pkg::ONE_Q16;
         s2_x2_ff    <= s2_x2_in;
      end
   end

   // stage 3: table read and higher power

   ecint_pkg::curve_type                    s3_curve_ff;
   logic                                    s3_upper_ff;
   logic signed [VALUE_BITS-1:0]            s3_start_ff;
   logic signed [DIF_BITS-1:0]              s3_dif_ff;
   logic [ecint_pkg::FRAC_BITS-1:0]         s3_frac_ff;
   logic [16:0]                             s3_lo_ff;
   logic [16:0]                             s3_hi_ff;
   logic                                    s3_xfull_ff;
   logic [31:0]                             s3_x2_ff;
   logic [63:0]                             s3_pw_ff;
   logic [63:0]                             s3_pw_in;
   logic [IDX_BITS-1:0]                     hi_idx;
   logic [31:0]                             pw_operand;

   assign hi_idx     = (s2_idx_ff == LAST_IDX) ? s2_idx_ff : s2_idx_ff + 1'b1;
   assign pw_operand = (s2_curve_ff.order == ecint_pkg::ORDER_QUART) ? s2_x2_ff
                                                                     : {16'b0, s2_x_ff};
   assign s3_pw_in   = {32'b0, s2_x2_ff} * {32'b0, pw_operand};

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_curve_ff <= s2_curve_ff;
         s3_upper_ff <= s2_upper_ff;
         s3_start_ff <= s2_start_ff;
         s3_dif_ff   <= s2_dif_ff;
         s3_frac_ff  <= s2_frac_ff;
         s3_lo_ff    <= sine_rom[s2_idx_ff];
         s3_hi_ff    <= sine_rom[hi_idx];
         s3_xfull_ff <= s2_xfull_ff;
         s3_x2_ff    <= s2_x2_ff;
         s3_pw_ff    <= s3_pw_in;
      end
   end

   // stage 4: interpolation step and power rounding

   ecint_pkg::curve_type                    s4_curve_ff;
   logic                                    s4_upper_ff;
   logic signed [VALUE_BITS-1:0]            s4_start_ff;
   logic signed [DIF_BITS-1:0]              s4_dif_ff;
   logic [16:0]                             s4_lo_ff;
   logic [16:0]                             s4_step_ff;
   logic [16:0]                             s4_epow_ff;
   logic [16:0]                             s4_epow_in;
   logic [16:0]                             delta;
   logic [32:0]                             step_prod;
   logic [POW_BITS-1:0]                     pw_base;
   logic [POW_BITS-1:0]                     pw_shifted;
   logic [POW_BITS-1:0]                     pw_rounded;
   logic [1:0]                              pw_shift;
   logic [16:0]                             pw_value;

   assign delta     = (s3_hi_ff >= s3_lo_ff) ? s3_hi_ff - s3_lo_ff : '0;
   assign step_prod = 33'(delta) * 33'(s3_frac_ff);

   always_comb begin
      pw_base  = (s3_curve_ff.order == ecint_pkg::ORDER_QUAD) ? POW_BITS'(s3_x2_ff)
                                                              : POW_BITS'(s3_pw_ff);
      pw_shift = (s3_curve_ff.mode == ecint_pkg::MODE_INOUT) ? 2'(s3_curve_ff.order) + 2'd1
                                                             : 2'd0;
      pw_shifted = pw_base << pw_shift;
      unique case (s3_curve_ff.order)
         ecint_pkg::ORDER_QUAD: begin
            pw_rounded = pw_shifted + (POW_BITS'(1) << 15);
            pw_value   = pw_rounded[16 +: 17];
         end
         ecint_pkg::ORDER_CUBIC: begin
            pw_rounded = pw_shifted + (POW_BITS'(1) << 31);
            pw_value   = pw_rounded[32 +: 17];
         end
         ecint_pkg::ORDER_QUART: begin
            pw_rounded = pw_shifted + (POW_BITS'(1) << 47);
            pw_value   = pw_rounded[48 +: 17];
         end
         default: begin
            pw_rounded = pw_shifted;
            pw_value   = '0;
         end
      endcase
      if (s3_xfull_ff) begin
         pw_value = ecint_pkg::ONE_Q16;
      end
      unique case (s3_curve_ff.mode)
         ecint_pkg::MODE_IN:    s4_epow_in = pw_value;
         ecint_pkg::MODE_OUT:   s4_epow_in = ecint_pkg::ONE_Q16 - pw_value;
         ecint_pkg::MODE_INOUT: s4_epow_in = s3_upper_ff ? ecint_pkg::ONE_Q16 - pw_value
                                                         : pw_value;
         default:               s4_epow_in = pw_value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_curve_ff <= s3_curve_ff;
         s4_upper_ff <= s3_upper_ff;
         s4_start_ff <= s3_start_ff;
         s4_dif_ff   <= s3_dif_ff;
         s4_lo_ff    <= s3_lo_ff;
         s4_step_ff  <= step_prod[32:16];
         s4_epow_ff  <= s4_epow_in;
      end
   end

   // stage 5: easing factor

   ecint_pkg::curve_type                    s5_curve_ff;
   logic                                    s5_upper_ff;
   logic signed [VALUE_BITS-1:0]            s5_start_ff;
   logic signed [DIF_BITS-1:0]              s5_dif_ff;
   logic [16:0]                             s5_e_ff;
   logic [16:0]                             s5_e_in;
   logic [16:0]                             sine_val;
   logic [17:0]                             sine_sum;
   logic [16:0]                             e_sine;

   assign sine_val = s4_lo_ff + s4_step_ff;

   always_comb begin
      sine_sum = 18'(ecint_pkg::ONE_Q16) - 18'(sine_val);
      unique case (s4_curve_ff.mode)
         ecint_pkg::MODE_IN:  e_sine = sine_sum[16:0];
         ecint_pkg::MODE_OUT: e_sine = sine_val;
         ecint_pkg::MODE_INOUT: begin
            if (s4_upper_ff) begin
               sine_sum = 18'(ecint_pkg::ONE_Q16) + 18'(sine_val);
            end
            e_sine = sine_sum[17:1];
         end
         default: e_sine = sine_val;
      endcase
      unique case (s4_curve_ff.family)
         ecint_pkg::FAMILY_SINE:  s5_e_in = e_sine;
         ecint_pkg::FAMILY_POWER: s5_e_in = s4_epow_ff;
         default:                 s5_e_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_curve_ff <= s4_curve_ff;
         s5_upper_ff <= s4_upper_ff;
         s5_start_ff <= s4_start_ff;
         s5_dif_ff   <= s4_dif_ff;
         s5_e_ff     <= s5_e_in;
      end
   end

   // stage 6: difference times factor

   logic signed [VALUE_BITS-1:0]            s6_start_ff;
   logic signed [PROD_BITS-1:0]             s6_prod_ff;
   logic signed [PROD_BITS-1:0]             s6_prod_in;
   logic signed [17:0]                      e_signed;

   assign e_signed   = signed'({1'b0, s5_e_ff});
   assign s6_prod_in = PROD_BITS'(s5_dif_ff) * PROD_BITS'(e_signed);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_start_ff <= s5_start_ff;
         s6_prod_ff  <= s6_prod_in;
      end
   end

   // stage 7: round and add, output register

   logic signed [VALUE_BITS-1:0]            s7_res_ff;
   logic signed [VALUE_BITS-1:0]            s7_res_in;
   logic signed [PROD_BITS-1:0]             prod_rounded;
   logic signed [PROD_BITS-1:0]             offset;

   assign prod_rounded = s6_prod_ff + PROD_BITS'(32768);
   assign offset       = prod_rounded >>> ecint_pkg::FRAC_BITS;
   assign s7_res_in    = s6_start_ff + VALUE_BITS'(offset);

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s7_res_ff <= s7_res_in;
      end
   end

   assign rsp_bus.valid       = vld_ff[LAST];
   assign rsp_bus.eased_value = s7_res_ff;

   // checks

   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> s5_e_ff <= ecint_pkg::ONE_Q16)
      else $error("easing factor above one");

   a_inout_halves: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] && s5_curve_ff.mode == ecint_pkg::MODE_INOUT
         && s5_curve_ff.family != ecint_pkg::FAMILY_NONE
      |-> (s5_upper_ff ? s5_e_ff >= ecint_pkg::HALF_Q16 : s5_e_ff <= ecint_pkg::HALF_Q16))
      else $error("in-out factor on the wrong side of one half");

   a_unused_kind: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] && s5_curve_ff.family == ecint_pkg::FAMILY_NONE |-> s5_e_ff == '0)
      else $error("unused kind gave nonzero factor");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> &vld_ff)
      else $error("input stalled with a free stage");

endmodule
